@@ sv/llcc_pkg.sv @@
// Shared types, constants and the saturation helper of the log-lag cross correlator.
package llcc_pkg;

	localparam int LINE_W = 10;
	localparam int COMP_W = 6;
	localparam int LAG_W = 6;
	localparam int CFG_W = 11;
	localparam int CIDX_W = 2;
	localparam int PAIR_W = 39;
	localparam int SUM_W = 50;
	localparam int CNT_W = 11;
	localparam int DIV_NW = 64;
	localparam int DIV_DW = 32;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_RUN = 1'b1;

	localparam logic [CIDX_W-1:0] REG_BLOCK_LEN = 2'd0;
	localparam logic [CIDX_W-1:0] REG_NUM_POINTS = 2'd1;
	localparam logic [CIDX_W-1:0] REG_NUM_Q = 2'd2;

	// One accepted input item.
	typedef struct packed {
		logic action;
		logic [LINE_W-1:0] line_index;
		logic [COMP_W-1:0] q_index;
		logic [31:0] stamp;
		logic [15:0] re_a;
		logic [15:0] im_a;
		logic [15:0] re_b;
		logic [15:0] im_b;
	} cmd_t;

	// Configuration after clamping to the legal ranges.
	typedef struct packed {
		logic [10:0] block_len;
		logic [6:0] num_points;
		logic [6:0] num_q;
	} cfg_t;

	// One result item.
	typedef struct packed {
		logic [LAG_W-1:0] lag_index;
		logic lag_valid;
		logic [31:0] lag_time;
		logic [31:0] corr_avg;
		logic [31:0] corr_norm;
		logic [16:0] pair_count;
		logic last;
	} res_t;

	// Per-lag accumulator entry.
	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] pairs;
		logic [31:0] stamp;
	} lag_ent_t;

	// Apply a sign to an unsigned quotient and saturate to 32 bits.
	function automatic logic [31:0] sat32(input logic neg, input logic [DIV_NW-1:0] q);
		logic [31:0] r;
		if (neg) begin
			if (q > 64'h0000_0000_8000_0000) r = 32'h8000_0000;
			else r = 32'(-q[31:0]);
		end else begin
			if (q > 64'h0000_0000_7FFF_FFFF) r = 32'h7FFF_FFFF;
			else r = q[31:0];
		end
		return r;
	endfunction

endpackage

@@ sv/llcc_div.sv @@
// Radix-2 restoring divider shared by the compute sequence.
module llcc_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [llcc_pkg::DIV_NW-1:0] num,
	input  logic [llcc_pkg::DIV_DW-1:0] den,
	output logic done,
	output logic [llcc_pkg::DIV_NW-1:0] quo
);

	logic busy_q;
	logic done_q;
	logic [5:0] cnt_q;
	logic [llcc_pkg::DIV_DW-1:0] rem_q;
	logic [llcc_pkg::DIV_DW-1:0] den_q;
	logic [llcc_pkg::DIV_NW-1:0] quo_q;
	logic [llcc_pkg::DIV_DW:0] trial;
	logic [llcc_pkg::DIV_DW:0] diff;
	logic ge;

	// One quotient bit per cycle.
	assign trial = {rem_q, quo_q[llcc_pkg::DIV_NW-1]};
	assign diff = trial - {1'b0, den_q};
	assign ge = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? diff[llcc_pkg::DIV_DW-1:0] : trial[llcc_pkg::DIV_DW-1:0];
			quo_q <= {quo_q[llcc_pkg::DIV_NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo = quo_q;

endmodule

@@ sv/llcc_front.sv @@
// Front end: configuration registers and the queue of accepted items.
module llcc_front (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  llcc_pkg::cmd_t cmd_in,
	input  logic cfg_we,
	input  logic [llcc_pkg::CIDX_W-1:0] cfg_index,
	input  logic [llcc_pkg::CFG_W-1:0] cfg_data,
	output logic cmd_valid,
	input  logic cmd_pop,
	output llcc_pkg::cmd_t cmd_out,
	output llcc_pkg::cfg_t cfg
);

	logic [10:0] block_len_q;
	logic [6:0] num_points_q;
	logic [6:0] num_q_q;
	llcc_pkg::cmd_t fifo_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] cnt_q;
	logic do_push;
	logic do_pop;

	// Configuration writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_len_q <= 11'd10;
			num_points_q <= 7'd64;
			num_q_q <= 7'd64;
		end else if (cfg_we) begin
			case (cfg_index)
				llcc_pkg::REG_BLOCK_LEN: block_len_q <= cfg_data;
				llcc_pkg::REG_NUM_POINTS: num_points_q <= cfg_data[6:0];
				llcc_pkg::REG_NUM_Q: num_q_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Clamp the registers to their working ranges.
	always_comb begin
		cfg.block_len = (block_len_q == 11'd0) ? 11'd1 :
			(block_len_q > 11'd1024) ? 11'd1024 : block_len_q;
		cfg.num_points = (num_points_q < 7'd2) ? 7'd2 :
			(num_points_q > 7'd64) ? 7'd64 : num_points_q;
		cfg.num_q = (num_q_q == 7'd0) ? 7'd1 :
			(num_q_q > 7'd64) ? 7'd64 : num_q_q;
	end

	// Four-entry item queue.
	assign full = cnt_q == 3'd4;
	assign cmd_valid = cnt_q != 3'd0;
	assign do_push = push && !full;
	assign do_pop = cmd_pop && cmd_valid;
	assign cmd_out = fifo_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 2'd1;
			if (do_pop) rd_q <= rd_q + 2'd1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 3'd1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) fifo_q[wr_q] <= cmd_in;
	end

endmodule

@@ sv/llcc_back.sv @@
// Back end: sample stores, lag accumulators and the compute sequencer.
module llcc_back (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_pop,
	input  llcc_pkg::cmd_t cmd,
	input  llcc_pkg::cfg_t cfg,
	output logic res_push,
	input  logic res_full,
	output llcc_pkg::res_t res
);

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_PDIV = 10'b0000000010,
		ST_PAIR = 10'b0000000100,
		ST_UPD  = 10'b0000001000,
		ST_FRD  = 10'b0000010000,
		ST_FA   = 10'b0000100000,
		ST_FAW  = 10'b0001000000,
		ST_FNX  = 10'b0010000000,
		ST_FNW  = 10'b0100000000,
		ST_EMIT = 10'b1000000000
	} state_t;

	state_t state_q;

	logic [31:0] a_mem [65536];
	logic [31:0] b_mem [65536];
	logic [31:0] lt_mem [1024];
	llcc_pkg::lag_ent_t lag_mem [64];

	logic [10:0] line_cnt_q;
	logic [10:0] nn_q;
	logic [6:0] ptsr_q;
	logic [6:0] nq_q;
	logic [10:0] nl_q;
	logic [6:0] pts_q;
	logic [10:0] org_q;
	logic [11:0] ln_q;
	logic [6:0] pt_q;
	logic [6:0] iss_q;
	logic [63:0] lv_q;

	logic [31:0] a_rd_s1;
	logic [31:0] b_rd_s1;
	logic v_s1;
	logic signed [31:0] pre_s2;
	logic signed [31:0] pim_s2;
	logic v_s2;
	logic signed [llcc_pkg::PAIR_W-1:0] acc_q;

	llcc_pkg::lag_ent_t lag_rd_q;
	logic [31:0] lt_rd_q;

	logic neg_q;
	logic [31:0] avg_q;
	logic [31:0] nrm_q;
	logic [31:0] cav0_q;
	logic [31:0] stamp0_q;

	logic div_start;
	logic [llcc_pkg::DIV_NW-1:0] div_num;
	logic [llcc_pkg::DIV_DW-1:0] div_den;
	logic div_done;
	logic [llcc_pkg::DIV_NW-1:0] div_quo;

	logic load_go;
	logic run_go;
	logic issue;
	logic pair_done;
	logic [11:0] maxnp;
	logic [6:0] pts_new;
	logic ok;
	llcc_pkg::lag_ent_t upd_ent;
	logic [6:0] pt_n;
	logic [11:0] ln_n;
	logic [11:0] org_n;
	logic [17:0] pq_mul;
	logic [29:0] ud;
	logic [llcc_pkg::SUM_W-1:0] abs_sum;
	logic [31:0] abs_avg;
	logic [31:0] abs_cav;
	logic norm_go;

	llcc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid;
	assign load_go = cmd_pop && (cmd.action == llcc_pkg::ACT_LOAD);
	assign run_go = cmd_pop && (cmd.action == llcc_pkg::ACT_RUN);

	// Sample and time stores.
	always_ff @(posedge clk) begin
		if (load_go) begin
			a_mem[{cmd.line_index, cmd.q_index}] <= {cmd.re_a, cmd.im_a};
			b_mem[{cmd.line_index, cmd.q_index}] <= {cmd.re_b, cmd.im_b};
			lt_mem[cmd.line_index] <= cmd.stamp;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			a_rd_s1 <= a_mem[{org_q[9:0], iss_q[5:0]}];
			b_rd_s1 <= b_mem[{ln_q[9:0], iss_q[5:0]}];
		end
		lt_rd_q <= lt_mem[ln_q[9:0]];
	end

	// Lag accumulator memory, read every cycle at the current lag point.
	always_ff @(posedge clk) begin
		if (state_q == ST_UPD) lag_mem[pt_q[5:0]] <= upd_ent;
		lag_rd_q <= lag_mem[pt_q[5:0]];
	end

	// Component pipeline: read, multiply, accumulate.
	assign issue = (state_q == ST_PAIR) && (iss_q < nq_q);
	assign pair_done = (state_q == ST_PAIR) && (iss_q == nq_q) && !v_s1 && !v_s2;

	always_ff @(posedge clk) begin
		pre_s2 <= $signed(a_rd_s1[31:16]) * $signed(b_rd_s1[31:16]);
		pim_s2 <= $signed(a_rd_s1[15:0]) * $signed(b_rd_s1[15:0]);
	end

	// Point limit from the line count and block length.
	always_comb begin
		if (nl_q == 11'd0) maxnp = {1'b0, nn_q} - 12'd1;
		else if (nl_q < nn_q) maxnp = {1'b0, nn_q};
		else maxnp = {1'b0, nn_q} - 12'd1 + {1'b0, div_quo[10:0]};
		pts_new = ({5'd0, ptsr_q} > maxnp) ? maxnp[6:0] : ptsr_q;
	end

	// Updated lag entry and the next pair. Lag points up to the block length
	// step one line; later points step a whole block.
	assign ok = lv_q[pt_q[5:0]];
	always_comb begin
		upd_ent.sum = (ok ? lag_rd_q.sum : '0) + llcc_pkg::SUM_W'(acc_q);
		upd_ent.pairs = (ok ? lag_rd_q.pairs : '0) + 11'd1;
		upd_ent.stamp = ok ? lag_rd_q.stamp : lt_rd_q;
		pt_n = pt_q + 7'd1;
		ln_n = ({4'd0, pt_n} <= {1'b0, nn_q}) ? ln_q + 12'd1 : ln_q + {1'b0, nn_q};
		org_n = {1'b0, org_q} + {1'b0, nn_q};
	end

	// Operands for the rounded divisions.
	always_comb begin
		pq_mul = 18'(lag_rd_q.pairs * nq_q);
		ud = {pq_mul, 12'd0};
		abs_sum = lag_rd_q.sum[llcc_pkg::SUM_W-1] ? llcc_pkg::SUM_W'(-lag_rd_q.sum) :
			lag_rd_q.sum;
		abs_avg = avg_q[31] ? 32'(-avg_q) : avg_q;
		abs_cav = cav0_q[31] ? 32'(-cav0_q) : cav0_q;
		norm_go = (pt_q != 7'd0) && ok && (cav0_q != 32'd0);
		div_start = 1'b0;
		div_num = '0;
		div_den = '0;
		case (state_q)
			ST_IDLE: begin
				div_start = run_go;
				div_num = 64'(line_cnt_q);
				div_den = 32'(cfg.block_len);
			end
			ST_FA: begin
				div_start = ok;
				div_num = 64'(abs_sum) + 64'(ud >> 1);
				div_den = 32'(ud);
			end
			ST_FNX: begin
				div_start = norm_go;
				div_num = {16'd0, abs_avg, 16'd0} + 64'(abs_cav >> 1);
				div_den = abs_cav;
			end
			default: ;
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			line_cnt_q <= '0;
			lv_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			iss_q <= '0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (issue) iss_q <= iss_q + 7'd1;
			case (state_q)
				ST_IDLE: begin
					if (load_go && ({1'b0, cmd.line_index} + 11'd1 > line_cnt_q))
						line_cnt_q <= {1'b0, cmd.line_index} + 11'd1;
					if (run_go) begin
						nn_q <= cfg.block_len;
						ptsr_q <= cfg.num_points;
						nq_q <= cfg.num_q;
						nl_q <= line_cnt_q;
						state_q <= ST_PDIV;
					end
				end
				ST_PDIV: begin
					if (div_done) begin
						pts_q <= pts_new;
						lv_q <= '0;
						org_q <= '0;
						ln_q <= '0;
						pt_q <= '0;
						iss_q <= '0;
						acc_q <= '0;
						if (pts_new < 7'd2) state_q <= ST_IDLE;
						else if (nl_q == 11'd0) state_q <= ST_FRD;
						else state_q <= ST_PAIR;
					end
				end
				ST_PAIR: begin
					if (v_s2) acc_q <= acc_q + llcc_pkg::PAIR_W'(pre_s2) +
						llcc_pkg::PAIR_W'(pim_s2);
					if (pair_done) state_q <= ST_UPD;
				end
				ST_UPD: begin
					lv_q[pt_q[5:0]] <= 1'b1;
					iss_q <= '0;
					acc_q <= '0;
					if ((ln_n < {1'b0, nl_q}) && (pt_n < pts_q)) begin
						ln_q <= ln_n;
						pt_q <= pt_n;
						state_q <= ST_PAIR;
					end else if (org_n < {1'b0, nl_q}) begin
						org_q <= org_n[10:0];
						ln_q <= org_n;
						pt_q <= '0;
						state_q <= ST_PAIR;
					end else begin
						pt_q <= '0;
						state_q <= ST_FRD;
					end
				end
				ST_FRD: state_q <= ST_FA;
				ST_FA: begin
					neg_q <= lag_rd_q.sum[llcc_pkg::SUM_W-1];
					if (ok) state_q <= ST_FAW;
					else begin
						avg_q <= '0;
						state_q <= ST_FNX;
					end
				end
				ST_FAW: begin
					if (div_done) begin
						avg_q <= llcc_pkg::sat32(neg_q, div_quo);
						state_q <= ST_FNX;
					end
				end
				ST_FNX: begin
					neg_q <= avg_q[31] ^ cav0_q[31];
					if (pt_q == 7'd0) begin
						cav0_q <= avg_q;
						stamp0_q <= ok ? lag_rd_q.stamp : 32'd0;
						pt_q <= 7'd1;
						state_q <= ST_FRD;
					end else if (norm_go) state_q <= ST_FNW;
					else begin
						nrm_q <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_FNW: begin
					if (div_done) begin
						nrm_q <= llcc_pkg::sat32(neg_q, div_quo);
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!res_full) begin
						if (pt_n < pts_q) begin
							pt_q <= pt_n;
							state_q <= ST_FRD;
						end else state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result item for the current lag point.
	assign res_push = (state_q == ST_EMIT) && !res_full;
	always_comb begin
		res.lag_index = pt_q[5:0];
		res.lag_valid = ok;
		res.lag_time = ok ? lag_rd_q.stamp - stamp0_q : 32'd0;
		res.corr_avg = avg_q;
		res.corr_norm = nrm_q;
		res.pair_count = ok ? pq_mul[16:0] : 17'd0;
		res.last = pt_n == pts_q;
	end

endmodule

@@ sv/log_lag_cross_correlator.sv @@
// Top level of the log-lag cross correlator with its result queue.
//
// Input channel: an item is taken when push is high and full is low. A load
// item (action 0) writes one sample of series A and B and the line's time
// stamp; a compute item (action 1) correlates all loaded lines and emits one
// result item per lag point 1 .. P-1, the final one with last set.
// Result channel: the oldest result sits on the ports while empty is low and
// leaves when pop is high. A two-entry result queue holds finished items, and
// the engine waits whenever that queue is full, so a stalled receiver only
// delays the computation, nothing is dropped.
// Loads are taken one per cycle while the item queue has room, and reach the
// stores through that queue while the engine is idle. A compute item first
// sets up the point count with a line-count division, then accumulates each
// pair over its nq components. Each lag point then divides its averaged sum,
// and each later point also its normalized value when point 0 has a nonzero
// average; a point with no pairs divides neither. All use the shared divider.
// Configuration writes take effect at once and must be made while idle.
// Reset empties both queues, restores the register defaults and clears the
// line count; the sample stores hold no meaningful data until written.
module log_lag_cross_correlator (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic action,
	input  logic [9:0] line_index,
	input  logic [5:0] q_index,
	input  logic [31:0] stamp,
	input  logic signed [15:0] re_a,
	input  logic signed [15:0] im_a,
	input  logic signed [15:0] re_b,
	input  logic signed [15:0] im_b,
	output logic empty,
	input  logic pop,
	output logic [5:0] lag_index,
	output logic lag_valid,
	output logic [31:0] lag_time,
	output logic signed [31:0] corr_avg,
	output logic signed [31:0] corr_norm,
	output logic [16:0] pair_count,
	output logic last,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [10:0] cfg_data
);

	llcc_pkg::cmd_t cmd_in;
	llcc_pkg::cmd_t cmd;
	llcc_pkg::cfg_t cfg;
	llcc_pkg::res_t res;
	llcc_pkg::res_t oq_q [2];
	llcc_pkg::res_t head;
	logic cmd_valid;
	logic cmd_pop;
	logic res_push;
	logic res_full;
	logic wr_q;
	logic rd_q;
	logic [1:0] cnt_q;
	logic do_pop;

	always_comb begin
		cmd_in.action = action;
		cmd_in.line_index = line_index;
		cmd_in.q_index = q_index;
		cmd_in.stamp = stamp;
		cmd_in.re_a = re_a;
		cmd_in.im_a = im_a;
		cmd_in.re_b = re_b;
		cmd_in.im_b = im_b;
	end

	llcc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.cmd_in    (cmd_in),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd_out   (cmd),
		.cfg       (cfg)
	);

	llcc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.cfg       (cfg),
		.res_push  (res_push),
		.res_full  (res_full),
		.res       (res)
	);

	// Two-entry result queue.
	assign res_full = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign do_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (res_push) wr_q <= ~wr_q;
			if (do_pop) rd_q <= ~rd_q;
			if (res_push && !do_pop) cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !res_push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) oq_q[wr_q] <= res;
	end

	assign head = oq_q[rd_q];
	assign lag_index = head.lag_index;
	assign lag_valid = head.lag_valid;
	assign lag_time = head.lag_time;
	assign corr_avg = head.corr_avg;
	assign corr_norm = head.corr_norm;
	assign pair_count = head.pair_count;
	assign last = head.last;

endmodule
